// ----- design/mssr_pkg.sv -----
package mssr_pkg;

    localparam int CMD_W       = 3;
    localparam int CH_W        = 3;
    localparam int IN_ANGLE_W  = 11;
    localparam int ANGLE_W     = 8;
    localparam int STEP_W      = 4;
    localparam int IVL_W       = 16;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int HOME_LEN    = 16;
    localparam int HOME_IDX_W  = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [CMD_W-1:0] {
        OP_TICK  = 3'd0,
        OP_MOVE  = 3'd1,
        OP_FORCE = 3'd2,
        OP_QUERY = 3'd3,
        OP_HOME  = 3'd4
    } op_t;

    localparam logic [KIND_W-1:0] KIND_STEP  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_IVL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_IVL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRIP_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRIP_CH    = 3'd5;

    localparam logic [STEP_W-1:0]  RST_STEP_SIZE  = 4'd1;
    localparam logic [IVL_W-1:0]   RST_MOVE_IVL   = 16'd25;
    localparam logic [IVL_W-1:0]   RST_HOME_IVL   = 16'd10;
    localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE  = 8'd180;
    localparam logic [ANGLE_W-1:0] RST_GRIP_LIMIT = 8'd110;
    localparam logic [CH_W-1:0]    RST_GRIP_CH    = 3'd3;
    localparam logic [ANGLE_W-1:0] RST_POSITION   = 8'd90;

    typedef struct packed {
        logic [STEP_W-1:0]  step_size;
        logic [IVL_W-1:0]   move_interval;
        logic [IVL_W-1:0]   home_interval;
        logic [ANGLE_W-1:0] max_angle;
        logic [ANGLE_W-1:0] gripper_limit;
        logic [CH_W-1:0]    gripper_channel;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [CH_W-1:0]    ch;
        logic               ch_ok;
        logic [ANGLE_W-1:0] target;
    } item_t;

    // home sequence: channel of each entry
    function automatic logic [CH_W-1:0] home_ch(input logic [HOME_IDX_W-1:0] i);
        logic [CH_W-1:0] r;
        case (i)
            4'd0:    r = 3'd0;
            4'd1:    r = 3'd1;
            4'd2:    r = 3'd2;
            4'd3:    r = 3'd3;
            4'd4,
            4'd5,
            4'd6,
            4'd7:    r = 3'd4;
            default: r = 3'd5;
        endcase
        return r;
    endfunction

    // home sequence: angle of each entry
    function automatic logic [ANGLE_W-1:0] home_deg(input logic [HOME_IDX_W-1:0] i);
        logic [ANGLE_W-1:0] r;
        case (i)
            4'd1:    r = 8'd145;
            4'd2:    r = 8'd40;
            4'd3:    r = 8'd110;
            4'd5,
            4'd7:    r = 8'd90;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // upper clamp, with the tighter gripper limit on its own channel
    function automatic logic [ANGLE_W-1:0] limit_target(
        input cfg_t               cfg,
        input logic [CH_W-1:0]    ch,
        input logic [ANGLE_W-1:0] t
    );
        logic [ANGLE_W-1:0] r;
        r = (t > cfg.max_angle) ? cfg.max_angle : t;
        if (ch == cfg.gripper_channel && r > cfg.gripper_limit)
        begin
            r = cfg.gripper_limit;
        end
        return r;
    endfunction

endpackage

// ----- design/mssr_front.sv -----
module mssr_front #(
    parameter int NUM_CHANNELS = 6
) (
    input  mssr_pkg::cfg_t                      cfg,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mssr_pkg::CMD_W-1:0]          cmd,
    input  logic [mssr_pkg::CH_W-1:0]           channel,
    input  logic signed [mssr_pkg::IN_ANGLE_W-1:0] angle,
    input  logic                                q_has_room,
    output logic                                q_push,
    output mssr_pkg::item_t                     q_item
);

    logic                             known;
    mssr_pkg::op_t                    op;
    logic [mssr_pkg::ANGLE_W-1:0]     pre;

    always_comb
    begin
        known = 1'b1;
        op    = mssr_pkg::OP_TICK;
        unique case (cmd)
            mssr_pkg::OP_TICK:  op = mssr_pkg::OP_TICK;
            mssr_pkg::OP_MOVE:  op = mssr_pkg::OP_MOVE;
            mssr_pkg::OP_FORCE: op = mssr_pkg::OP_FORCE;
            mssr_pkg::OP_QUERY: op = mssr_pkg::OP_QUERY;
            mssr_pkg::OP_HOME:  op = mssr_pkg::OP_HOME;
            default:            known = 1'b0;
        endcase
    end

    // negative saturates to zero, anything past eight bits to the top
    always_comb
    begin
        if (angle[mssr_pkg::IN_ANGLE_W-1])
        begin
            pre = '0;
        end
        else if (angle[mssr_pkg::IN_ANGLE_W-2:mssr_pkg::ANGLE_W] != '0)
        begin
            pre = '1;
        end
        else
        begin
            pre = angle[mssr_pkg::ANGLE_W-1:0];
        end
    end

    assign in_ready      = q_has_room;
    assign q_push        = in_valid && q_has_room && known;
    assign q_item.op     = op;
    assign q_item.ch     = channel;
    assign q_item.ch_ok  = {1'b0, channel} < (mssr_pkg::CH_W+1)'(NUM_CHANNELS);
    assign q_item.target = mssr_pkg::limit_target(cfg, channel, pre);

endmodule

// ----- design/mssr_queue.sv -----
module mssr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mssr_pkg::item_t  push_item,
    output logic             has_room,
    input  logic             pop,
    output logic             not_empty,
    output mssr_pkg::item_t  pop_item
);

    localparam int PTR_W = (mssr_pkg::QUEUE_PTR_W > 0) ? mssr_pkg::QUEUE_PTR_W : 1;

    mssr_pkg::item_t        entry_reg [mssr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]         count_reg, count_next;

    assign has_room  = count_reg != (PTR_W+1)'(mssr_pkg::QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(mssr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(mssr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- design/mssr_back.sv -----
module mssr_back #(
    parameter int NUM_CHANNELS    = 6,
    parameter int HOME_STEPS      = 9,
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mssr_pkg::cfg_t                    cfg,
    input  logic                              q_not_empty,
    input  mssr_pkg::item_t                   q_item,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mssr_pkg::KIND_W-1:0]       kind,
    output logic [mssr_pkg::STATUS_W-1:0]     status,
    output logic [mssr_pkg::CH_W-1:0]         out_channel,
    output logic [mssr_pkg::ANGLE_W-1:0]      position,
    output logic                              busy_res,
    output logic                              ramp_done
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CMP_W = (TICK_COUNT_BITS > mssr_pkg::IVL_W) ? TICK_COUNT_BITS
                                                                : mssr_pkg::IVL_W;
    localparam int AW    = mssr_pkg::ANGLE_W;
    localparam int HW    = mssr_pkg::HOME_IDX_W;
    localparam int CW    = mssr_pkg::CH_W;

    // per-channel angles and ramp state
    logic [AW-1:0]              pos_reg [NUM_CHANNELS];
    logic                       ramp_active_reg, ramp_active_next;
    logic                       home_active_reg, home_active_next;
    logic [CW-1:0]              ramp_ch_reg, ramp_ch_next;
    logic [AW-1:0]              ramp_target_reg, ramp_target_next;
    logic [TICK_COUNT_BITS-1:0] tick_reg, tick_next;
    logic [HW-1:0]              home_idx_reg, home_idx_next;

    logic                       out_valid_reg, out_valid_next;
    logic [mssr_pkg::KIND_W-1:0]   kind_reg;
    logic [mssr_pkg::STATUS_W-1:0] status_reg;
    logic [CW-1:0]              out_ch_reg;
    logic [AW-1:0]              position_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic                       fire;
    logic                       busy;
    mssr_pkg::op_t              op;

    // home sequence search
    logic [HW:0]                start;
    logic [mssr_pkg::HOME_LEN-1:0] cand;
    logic [AW-1:0]              tgt_tab [mssr_pkg::HOME_LEN];
    logic                       hit;
    logic [HW-1:0]              hit_idx;
    logic [CW-1:0]              hit_ch;

    // shared read port
    logic [IDX_W-1:0]           rd_addr;
    logic [AW-1:0]              rd_pos;

    // step datapath
    logic [TICK_COUNT_BITS-1:0] tick_inc;
    logic [mssr_pkg::IVL_W-1:0] interval;
    logic                       step_due;
    logic [AW-1:0]              st8;
    logic                       up;
    logic [AW-1:0]              diff;
    logic [AW-1:0]              new_pos;
    logic                       done;

    // result and store write
    logic                       res_valid;
    logic [mssr_pkg::KIND_W-1:0]   res_kind;
    logic [mssr_pkg::STATUS_W-1:0] res_status;
    logic [CW-1:0]              res_ch;
    logic [AW-1:0]              res_pos;
    logic                       res_done;
    logic                       pos_we;
    logic [IDX_W-1:0]           pos_wa;
    logic [AW-1:0]              pos_wd;

    assign op    = q_item.op;
    assign busy  = ramp_active_reg || home_active_reg;
    assign fire  = q_not_empty && (!out_valid_reg || out_ready);
    assign q_pop = fire;

    // after a finished step the sequence resumes from the next entry
    assign start = (op == mssr_pkg::OP_TICK) ? {1'b0, home_idx_reg} + 1'b1 : '0;

    for (genvar i = 0; i < mssr_pkg::HOME_LEN; i++)
    begin : gen_home
        localparam logic [CW-1:0] HC = mssr_pkg::home_ch(HW'(i));
        if (i < HOME_STEPS && int'(HC) < NUM_CHANNELS)
        begin : gen_live
            logic [AW-1:0] t_i;
            logic [AW-1:0] cur_i;
            assign t_i   = mssr_pkg::limit_target(cfg, HC, mssr_pkg::home_deg(HW'(i)));
            // the finished ramp channel already sits at its target
            assign cur_i = (op == mssr_pkg::OP_TICK && ramp_ch_reg == HC) ? ramp_target_reg
                                                                          : pos_reg[HC];
            assign cand[i]    = ((HW+1)'(i) >= start) && (t_i != cur_i);
            assign tgt_tab[i] = t_i;
        end
        else
        begin : gen_dead
            assign cand[i]    = 1'b0;
            assign tgt_tab[i] = '0;
        end
    end

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = mssr_pkg::HOME_LEN - 1; k >= 0; k--)
        begin
            if (cand[k])
            begin
                hit     = 1'b1;
                hit_idx = HW'(k);
            end
        end
    end

    assign hit_ch = mssr_pkg::home_ch(hit_idx);

    always_comb
    begin
        case (op)
            mssr_pkg::OP_TICK: rd_addr = IDX_W'(ramp_ch_reg);
            mssr_pkg::OP_HOME: rd_addr = hit ? IDX_W'(hit_ch) : '0;
            default:           rd_addr = q_item.ch_ok ? IDX_W'(q_item.ch) : '0;
        endcase
    end

    assign rd_pos = pos_reg[rd_addr];

    assign tick_inc = (tick_reg != '1) ? tick_reg + 1'b1 : tick_reg;
    assign interval = home_active_reg ? cfg.home_interval : cfg.move_interval;
    assign step_due = CMP_W'(tick_inc) >= CMP_W'(interval);
    assign st8      = (cfg.step_size == '0) ? AW'(1) : AW'(cfg.step_size);
    assign up       = rd_pos < ramp_target_reg;
    assign diff     = up ? ramp_target_reg - rd_pos : rd_pos - ramp_target_reg;
    assign new_pos  = (diff <= st8) ? ramp_target_reg
                                    : (up ? rd_pos + st8 : rd_pos - st8);
    assign done     = new_pos == ramp_target_reg;

    always_comb
    begin
        ramp_active_next = ramp_active_reg;
        home_active_next = home_active_reg;
        ramp_ch_next     = ramp_ch_reg;
        ramp_target_next = ramp_target_reg;
        tick_next        = tick_reg;
        home_idx_next    = home_idx_reg;
        res_valid        = 1'b0;
        res_kind         = mssr_pkg::KIND_ACK;
        res_status       = mssr_pkg::ST_OK;
        res_ch           = q_item.ch;
        res_pos          = '0;
        res_done         = 1'b0;
        pos_we           = 1'b0;
        pos_wa           = rd_addr;
        pos_wd           = q_item.target;

        case (op)
            mssr_pkg::OP_TICK:
            begin
                if (ramp_active_reg)
                begin
                    tick_next = tick_inc;
                    if (step_due)
                    begin
                        tick_next  = '0;
                        pos_we     = 1'b1;
                        pos_wd     = new_pos;
                        res_valid  = 1'b1;
                        res_kind   = mssr_pkg::KIND_STEP;
                        res_ch     = ramp_ch_reg;
                        res_pos    = new_pos;
                        res_done   = done;
                        if (done && home_active_reg)
                        begin
                            if (hit)
                            begin
                                home_idx_next    = hit_idx;
                                ramp_ch_next     = hit_ch;
                                ramp_target_next = tgt_tab[hit_idx];
                            end
                            else
                            begin
                                ramp_active_next = 1'b0;
                                home_active_next = 1'b0;
                                home_idx_next    = '0;
                            end
                        end
                        else if (done)
                        begin
                            ramp_active_next = 1'b0;
                        end
                    end
                end
            end
            mssr_pkg::OP_MOVE,
            mssr_pkg::OP_FORCE:
            begin
                res_valid = 1'b1;
                if (busy)
                begin
                    res_status = mssr_pkg::ST_BUSY;
                    res_pos    = q_item.ch_ok ? rd_pos : '0;
                end
                else if (!q_item.ch_ok)
                begin
                    res_status = mssr_pkg::ST_BAD_CH;
                end
                else if (op == mssr_pkg::OP_FORCE)
                begin
                    pos_we  = 1'b1;
                    res_pos = q_item.target;
                end
                else
                begin
                    res_pos = rd_pos;
                    if (q_item.target != rd_pos)
                    begin
                        ramp_active_next = 1'b1;
                        ramp_ch_next     = q_item.ch;
                        ramp_target_next = q_item.target;
                        tick_next        = '0;
                    end
                end
            end
            mssr_pkg::OP_QUERY:
            begin
                res_valid  = 1'b1;
                res_kind   = mssr_pkg::KIND_QUERY;
                res_status = q_item.ch_ok ? mssr_pkg::ST_OK : mssr_pkg::ST_BAD_CH;
                res_pos    = q_item.ch_ok ? rd_pos : '0;
            end
            mssr_pkg::OP_HOME:
            begin
                res_valid = 1'b1;
                if (busy)
                begin
                    res_status = mssr_pkg::ST_BUSY;
                end
                else
                begin
                    res_ch  = hit ? hit_ch : '0;
                    res_pos = rd_pos;
                    if (hit)
                    begin
                        ramp_active_next = 1'b1;
                        home_active_next = 1'b1;
                        home_idx_next    = hit_idx;
                        ramp_ch_next     = hit_ch;
                        ramp_target_next = tgt_tab[hit_idx];
                        tick_next        = '0;
                    end
                    else
                    begin
                        home_idx_next = '0;
                    end
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (fire && res_valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                pos_reg[k] <= mssr_pkg::RST_POSITION;
            end
            ramp_active_reg <= 1'b0;
            home_active_reg <= 1'b0;
            ramp_ch_reg     <= '0;
            ramp_target_reg <= '0;
            tick_reg        <= '0;
            home_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                if (pos_we)
                begin
                    pos_reg[pos_wa] <= pos_wd;
                end
                ramp_active_reg <= ramp_active_next;
                home_active_reg <= home_active_next;
                ramp_ch_reg     <= ramp_ch_next;
                ramp_target_reg <= ramp_target_next;
                tick_reg        <= tick_next;
                home_idx_reg    <= home_idx_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            kind_reg     <= res_kind;
            status_reg   <= res_status;
            out_ch_reg   <= res_ch;
            position_reg <= res_pos;
            busy_reg     <= ramp_active_next || home_active_next;
            done_reg     <= res_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign status      = status_reg;
    assign out_channel = out_ch_reg;
    assign position    = position_reg;
    assign busy_res    = busy_reg;
    assign ramp_done   = done_reg;

endmodule

// ----- design/multi_servo_slew_ramp.sv -----
// channel   handshake                 payload
// input     in_valid / in_ready       cmd, channel, angle
// result    out_valid / out_ready     kind, status, out_channel, position, busy_res, ramp_done
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one word per cycle in and out when not stalled; results pass the queue and output register
// the cycle is set by the home sequence search that follows a finished step
// reset puts every channel at 90 degrees with no ramp running, no clearing pass
// a two-word queue sits between decode and execution, the result is held in an
// output register, so a stalled result holds back input only once the queue fills
module multi_servo_slew_ramp #(
    parameter int NUM_CHANNELS    = 6,
    parameter int HOME_STEPS      = 9,
    parameter int TICK_COUNT_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [mssr_pkg::CMD_W-1:0]             cmd,
    input  logic [mssr_pkg::CH_W-1:0]              channel,
    input  logic signed [mssr_pkg::IN_ANGLE_W-1:0] angle,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [mssr_pkg::KIND_W-1:0]            kind,
    output logic [mssr_pkg::STATUS_W-1:0]          status,
    output logic [mssr_pkg::CH_W-1:0]              out_channel,
    output logic [mssr_pkg::ANGLE_W-1:0]           position,
    output logic                                   busy_res,
    output logic                                   ramp_done,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mssr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [mssr_pkg::CFG_DATA_W-1:0]        cfg_data
);

    mssr_pkg::cfg_t  cfg_reg;
    logic            q_has_room;
    logic            q_push;
    mssr_pkg::item_t q_push_item;
    logic            q_pop;
    logic            q_not_empty;
    mssr_pkg::item_t q_pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size       <= mssr_pkg::RST_STEP_SIZE;
            cfg_reg.move_interval   <= mssr_pkg::RST_MOVE_IVL;
            cfg_reg.home_interval   <= mssr_pkg::RST_HOME_IVL;
            cfg_reg.max_angle       <= mssr_pkg::RST_MAX_ANGLE;
            cfg_reg.gripper_limit   <= mssr_pkg::RST_GRIP_LIMIT;
            cfg_reg.gripper_channel <= mssr_pkg::RST_GRIP_CH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mssr_pkg::CFG_STEP_SIZE:
                    cfg_reg.step_size <= cfg_data[mssr_pkg::STEP_W-1:0];
                mssr_pkg::CFG_MOVE_IVL:
                    cfg_reg.move_interval <= cfg_data[mssr_pkg::IVL_W-1:0];
                mssr_pkg::CFG_HOME_IVL:
                    cfg_reg.home_interval <= cfg_data[mssr_pkg::IVL_W-1:0];
                mssr_pkg::CFG_MAX_ANGLE:
                    cfg_reg.max_angle <= cfg_data[mssr_pkg::ANGLE_W-1:0];
                mssr_pkg::CFG_GRIP_LIMIT:
                    cfg_reg.gripper_limit <= cfg_data[mssr_pkg::ANGLE_W-1:0];
                mssr_pkg::CFG_GRIP_CH:
                    cfg_reg.gripper_channel <= cfg_data[mssr_pkg::CH_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    mssr_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .channel    (channel),
        .angle      (angle),
        .q_has_room (q_has_room),
        .q_push     (q_push),
        .q_item     (q_push_item)
    );

    mssr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .has_room  (q_has_room),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (q_pop_item)
    );

    mssr_back #(
        .NUM_CHANNELS    (NUM_CHANNELS),
        .HOME_STEPS      (HOME_STEPS),
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_not_empty (q_not_empty),
        .q_item      (q_pop_item),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .status      (status),
        .out_channel (out_channel),
        .position    (position),
        .busy_res    (busy_res),
        .ramp_done   (ramp_done)
    );

endmodule
